@@ hw/rtl/nfcs_pkg.sv @@
// ----------------------------------------------------------------------------
// NOR flash command sequencer package
// Shared types and constants for the command sequencer.
// ----------------------------------------------------------------------------
package nfcs_pkg;

  localparam int MAX_RESULTS = 7;

  typedef enum logic [1:0] {
    OP_PROGRAM  = 2'd0,
    OP_ERASE    = 2'd1,
    OP_READ_ID  = 2'd2,
    OP_RESPONSE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_MISMATCH = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_PROG_POLL   = 3'd1,
    PH_PROG_VERIFY = 3'd2,
    PH_ERASE_PRE   = 3'd3,
    PH_ERASE_POLL  = 3'd4,
    PH_ID_READ     = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    POLL_AGAIN   = 2'd0,
    POLL_SETTLED = 2'd1,
    POLL_TIMEOUT = 2'd2
  } poll_t;

  typedef enum logic {
    CFG_POLL_LIMIT = 1'b0,
    CFG_BUS_BASE   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    kind_t       kind;
    logic [21:0] addr;
    logic [15:0] data;
    status_t     status;
  } result_t;

  localparam logic [15:0] TOGGLE_BIT      = 16'h0040;
  localparam logic [15:0] UNLOCK_A1       = 16'h5555;
  localparam logic [15:0] UNLOCK_A2       = 16'h2aaa;
  localparam logic [15:0] UNLOCK_D1       = 16'h00aa;
  localparam logic [15:0] UNLOCK_D2       = 16'h0055;
  localparam logic [15:0] CMD_PROGRAM     = 16'h00a0;
  localparam logic [15:0] CMD_ERASE_SETUP = 16'h0080;
  localparam logic [15:0] CMD_SECTOR      = 16'h0050;
  localparam logic [15:0] CMD_ID          = 16'h0090;
  localparam logic [15:0] CMD_RESET       = 16'h00f0;
  localparam logic [25:0] POLL_RESET      = 26'h2000000;

endpackage

@@ hw/rtl/nor_flash_command_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// NOR flash command sequencer
// Turns program, erase and read-ID requests into JEDEC bus cycles and
// polls the toggle bit through the read responses that come back.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   -------------------------------------
//  in        in_valid / in_ready     operation, address, write_data,
//                                    length, read_data
//  out       out_valid / out_ready   kind, bus_address, bus_data, status, last
//  cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An accepted item is held in the input register; its whole burst of results
// (up to seven) is worked out in one pass and loaded into the result buffer,
// which drains one result per cycle while out_ready is high. An item is taken
// in every cycle while the buffer is free; an item with k results holds the
// next one back until all k have drained, so the output port sets the rate.
// The next burst loads in the cycle the last result of the current one is
// taken. Reset is synchronous; the configuration port is always ready.
module nor_flash_command_sequencer_top #(
  parameter int ADDR_WIDTH   = 22,
  parameter int SECTOR_WORDS = 2048
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [21:0] address,
  input  logic [15:0] write_data,
  input  logic [22:0] length,
  input  logic [15:0] read_data,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [21:0] bus_address,
  output logic [15:0] bus_data,
  output logic [1:0]  status,
  output logic        last,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [25:0] cfg_data
);

  localparam int AW = ADDR_WIDTH;

  // Configuration registers.
  logic [25:0] poll_limit;
  logic [21:0] bus_base;

  // Sequencer state.
  nfcs_pkg::phase_t phase, phase_next;
  nfcs_pkg::op_t    active_request, active_request_next;
  logic [AW-1:0]    target_address, target_address_next;
  logic [15:0]      expected_word, expected_word_next;
  logic [22:0]      erase_end, erase_end_next;
  logic             prior_toggle, prior_toggle_next;
  logic [25:0]      poll_count, poll_count_next;
  logic             first_poll_read, first_poll_read_next;

  // Input register.
  logic             s1_valid;
  nfcs_pkg::op_t    s1_op;
  logic [21:0]      s1_address;
  logic [15:0]      s1_write_data;
  logic [22:0]      s1_length;
  logic [15:0]      s1_read_data;

  // Result buffer.
  nfcs_pkg::result_t batch [nfcs_pkg::MAX_RESULTS];
  logic [2:0]        batch_cnt;
  logic [2:0]        batch_idx;

  nfcs_pkg::result_t gen [nfcs_pkg::MAX_RESULTS];
  logic [2:0]        gen_cnt;

  logic out_fire, drain_end, batch_free, s1_take;

  // Poll step.
  logic            toggle;
  nfcs_pkg::poll_t poll_res;
  logic            poll_prior_next;
  logic            poll_first_next;
  logic [25:0]     poll_count_step;

  // Addresses.
  logic [AW-1:0] req_target;
  logic [AW-1:0] next_sector;
  logic [21:0]   addr_a1, addr_a2, addr_id, addr_base, addr_tgt;

  function automatic nfcs_pkg::result_t mk_res(nfcs_pkg::kind_t k, logic [21:0] a,
                                               logic [15:0] d, nfcs_pkg::status_t s);
    nfcs_pkg::result_t r;
    r.kind   = k;
    r.addr   = a;
    r.data   = d;
    r.status = s;
    return r;
  endfunction

  function automatic nfcs_pkg::result_t mk_wr(logic [21:0] a, logic [15:0] d);
    return mk_res(nfcs_pkg::KIND_WRITE, a, d, nfcs_pkg::ST_OK);
  endfunction

  function automatic nfcs_pkg::result_t mk_rd(logic [21:0] a);
    return mk_res(nfcs_pkg::KIND_READ, a, 16'd0, nfcs_pkg::ST_OK);
  endfunction

  function automatic nfcs_pkg::result_t mk_done(logic [15:0] d, nfcs_pkg::status_t s);
    return mk_res(nfcs_pkg::KIND_DONE, 22'd0, d, s);
  endfunction

  // ------------------------------------------------------------------
  // Handshakes
  // ------------------------------------------------------------------
  assign out_valid  = (batch_cnt != 3'd0);
  assign out_fire   = out_valid && out_ready;
  assign drain_end  = out_fire && (batch_idx == batch_cnt - 3'd1);
  assign batch_free = !out_valid || drain_end;
  assign s1_take    = s1_valid && batch_free;
  assign in_ready   = !s1_valid || s1_take;
  assign cfg_ready  = 1'b1;

  assign kind        = batch[batch_idx].kind;
  assign bus_address = batch[batch_idx].addr;
  assign bus_data    = batch[batch_idx].data;
  assign status      = batch[batch_idx].status;
  assign last        = (batch_idx == batch_cnt - 3'd1);

  // ------------------------------------------------------------------
  // Address arithmetic, all modulo the flash address space
  // ------------------------------------------------------------------
  assign req_target  = AW'(bus_base) + AW'(s1_address);
  assign next_sector = target_address + AW'(SECTOR_WORDS);
  assign addr_a1     = 22'(AW'(bus_base) + AW'(nfcs_pkg::UNLOCK_A1));
  assign addr_a2     = 22'(AW'(bus_base) + AW'(nfcs_pkg::UNLOCK_A2));
  assign addr_id     = 22'(AW'(bus_base) + AW'(1'b1));
  assign addr_base   = 22'(AW'(bus_base));
  assign addr_tgt    = 22'(target_address);

  // ------------------------------------------------------------------
  // Toggle-bit poll step
  // ------------------------------------------------------------------
  assign toggle = |(s1_read_data & nfcs_pkg::TOGGLE_BIT);

  always_comb begin
    poll_res        = nfcs_pkg::POLL_AGAIN;
    poll_prior_next = prior_toggle;
    poll_first_next = first_poll_read;
    poll_count_step = poll_count;
    if (first_poll_read) begin
      poll_first_next = 1'b0;
      poll_prior_next = toggle;
    end else if (toggle == prior_toggle) begin
      poll_res = nfcs_pkg::POLL_SETTLED;
    end else begin
      poll_prior_next = toggle;
      if (poll_count >= poll_limit) begin
        poll_res = nfcs_pkg::POLL_TIMEOUT;
      end else begin
        poll_count_step = poll_count + 26'd1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Result burst and next state for the item in the input register
  // ------------------------------------------------------------------
  always_comb begin
    gen                  = '{default: '0};
    gen_cnt              = 3'd0;
    phase_next           = phase;
    active_request_next  = active_request;
    target_address_next  = target_address;
    expected_word_next   = expected_word;
    erase_end_next       = erase_end;
    prior_toggle_next    = prior_toggle;
    poll_count_next      = poll_count;
    first_poll_read_next = first_poll_read;

    unique case (s1_op)
      nfcs_pkg::OP_PROGRAM: begin
        if (phase == nfcs_pkg::PH_IDLE) begin
          active_request_next  = s1_op;
          target_address_next  = req_target;
          expected_word_next   = s1_write_data;
          gen[0]               = mk_wr(addr_a1, nfcs_pkg::UNLOCK_D1);
          gen[1]               = mk_wr(addr_a2, nfcs_pkg::UNLOCK_D2);
          gen[2]               = mk_wr(addr_a1, nfcs_pkg::CMD_PROGRAM);
          gen[3]               = mk_wr(22'(req_target), s1_write_data);
          gen[4]               = mk_rd(22'(req_target));
          gen_cnt              = 3'd5;
          phase_next           = nfcs_pkg::PH_PROG_POLL;
          first_poll_read_next = 1'b1;
          poll_count_next      = 26'd0;
        end
      end
      nfcs_pkg::OP_ERASE: begin
        if (phase == nfcs_pkg::PH_IDLE) begin
          active_request_next = s1_op;
          gen_cnt             = 3'd1;
          if (s1_length == 23'd0) begin
            gen[0] = mk_done(16'd0, nfcs_pkg::ST_OK);
          end else begin
            target_address_next  = req_target;
            erase_end_next       = s1_length;
            gen[0]               = mk_rd(22'(req_target));
            phase_next           = nfcs_pkg::PH_ERASE_PRE;
            first_poll_read_next = 1'b1;
            poll_count_next      = 26'd0;
          end
        end
      end
      nfcs_pkg::OP_READ_ID: begin
        if (phase == nfcs_pkg::PH_IDLE) begin
          active_request_next = s1_op;
          gen[0]              = mk_wr(addr_a1, nfcs_pkg::UNLOCK_D1);
          gen[1]              = mk_wr(addr_a2, nfcs_pkg::UNLOCK_D2);
          gen[2]              = mk_wr(addr_a1, nfcs_pkg::CMD_ID);
          gen[3]              = mk_rd(addr_id);
          gen_cnt             = 3'd4;
          phase_next          = nfcs_pkg::PH_ID_READ;
        end
      end
      nfcs_pkg::OP_RESPONSE: begin
        unique case (phase)
          nfcs_pkg::PH_PROG_POLL: begin
            prior_toggle_next    = poll_prior_next;
            first_poll_read_next = poll_first_next;
            poll_count_next      = poll_count_step;
            gen_cnt              = 3'd1;
            if (poll_res == nfcs_pkg::POLL_TIMEOUT) begin
              gen[0]     = mk_done(16'd0, nfcs_pkg::ST_TIMEOUT);
              phase_next = nfcs_pkg::PH_IDLE;
            end else begin
              gen[0] = mk_rd(addr_tgt);
              if (poll_res == nfcs_pkg::POLL_SETTLED) begin
                phase_next = nfcs_pkg::PH_PROG_VERIFY;
              end
            end
          end
          nfcs_pkg::PH_PROG_VERIFY: begin
            phase_next = nfcs_pkg::PH_IDLE;
            if (s1_read_data == expected_word) begin
              gen[0]  = mk_done(16'd0, nfcs_pkg::ST_OK);
              gen_cnt = 3'd1;
            end else begin
              gen[0]  = mk_wr(addr_tgt, nfcs_pkg::CMD_RESET);
              gen[1]  = mk_done(16'd0, nfcs_pkg::ST_MISMATCH);
              gen_cnt = 3'd2;
            end
          end
          nfcs_pkg::PH_ERASE_PRE: begin
            prior_toggle_next    = poll_prior_next;
            first_poll_read_next = poll_first_next;
            poll_count_next      = poll_count_step;
            if (poll_res == nfcs_pkg::POLL_AGAIN) begin
              gen[0]  = mk_rd(addr_tgt);
              gen_cnt = 3'd1;
            end else begin
              // The pre-poll outcome is ignored: the sector command follows.
              gen[0]               = mk_wr(addr_a1, nfcs_pkg::UNLOCK_D1);
              gen[1]               = mk_wr(addr_a2, nfcs_pkg::UNLOCK_D2);
              gen[2]               = mk_wr(addr_a1, nfcs_pkg::CMD_ERASE_SETUP);
              gen[3]               = mk_wr(addr_a1, nfcs_pkg::UNLOCK_D1);
              gen[4]               = mk_wr(addr_a2, nfcs_pkg::UNLOCK_D2);
              gen[5]               = mk_wr(addr_tgt, nfcs_pkg::CMD_SECTOR);
              gen[6]               = mk_rd(addr_tgt);
              gen_cnt              = 3'd7;
              phase_next           = nfcs_pkg::PH_ERASE_POLL;
              first_poll_read_next = 1'b1;
              poll_count_next      = 26'd0;
            end
          end
          nfcs_pkg::PH_ERASE_POLL: begin
            prior_toggle_next    = poll_prior_next;
            first_poll_read_next = poll_first_next;
            poll_count_next      = poll_count_step;
            gen_cnt              = 3'd1;
            unique case (poll_res)
              nfcs_pkg::POLL_SETTLED: begin
                if (erase_end <= 23'(SECTOR_WORDS)) begin
                  erase_end_next = 23'd0;
                  gen[0]         = mk_done(16'd0, nfcs_pkg::ST_OK);
                  phase_next     = nfcs_pkg::PH_IDLE;
                end else begin
                  erase_end_next       = erase_end - 23'(SECTOR_WORDS);
                  target_address_next  = next_sector;
                  gen[0]               = mk_rd(22'(next_sector));
                  phase_next           = nfcs_pkg::PH_ERASE_PRE;
                  first_poll_read_next = 1'b1;
                  poll_count_next      = 26'd0;
                end
              end
              nfcs_pkg::POLL_TIMEOUT: begin
                gen[0]     = mk_done(16'd0, nfcs_pkg::ST_TIMEOUT);
                phase_next = nfcs_pkg::PH_IDLE;
              end
              default: begin
                gen[0] = mk_rd(addr_tgt);
              end
            endcase
          end
          nfcs_pkg::PH_ID_READ: begin
            gen[0]     = mk_wr(addr_base, nfcs_pkg::CMD_RESET);
            gen[1]     = mk_done(s1_read_data, nfcs_pkg::ST_OK);
            gen_cnt    = 3'd2;
            phase_next = nfcs_pkg::PH_IDLE;
          end
          default: begin
            // A read response with no request outstanding is dropped.
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= nfcs_pkg::POLL_RESET;
      bus_base   <= 22'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (nfcs_pkg::cfg_reg_t'(cfg_index))
        nfcs_pkg::CFG_POLL_LIMIT: poll_limit <= cfg_data;
        nfcs_pkg::CFG_BUS_BASE:   bus_base   <= cfg_data[21:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op         <= nfcs_pkg::op_t'(operation);
      s1_address    <= address;
      s1_write_data <= write_data;
      s1_length     <= length;
      s1_read_data  <= read_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= nfcs_pkg::PH_IDLE;
      active_request  <= nfcs_pkg::OP_PROGRAM;
      target_address  <= '0;
      expected_word   <= 16'd0;
      erase_end       <= 23'd0;
      prior_toggle    <= 1'b0;
      poll_count      <= 26'd0;
      first_poll_read <= 1'b0;
    end else if (s1_take) begin
      phase           <= phase_next;
      active_request  <= active_request_next;
      target_address  <= target_address_next;
      expected_word   <= expected_word_next;
      erase_end       <= erase_end_next;
      prior_toggle    <= prior_toggle_next;
      poll_count      <= poll_count_next;
      first_poll_read <= first_poll_read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && gen_cnt != 3'd0) begin
      batch <= gen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_cnt <= 3'd0;
      batch_idx <= 3'd0;
    end else if (s1_take && gen_cnt != 3'd0) begin
      batch_cnt <= gen_cnt;
      batch_idx <= 3'd0;
    end else if (drain_end) begin
      batch_cnt <= 3'd0;
      batch_idx <= 3'd0;
    end else if (out_fire) begin
      batch_idx <= batch_idx + 3'd1;
    end
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_idx_in_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (batch_idx < batch_cnt))
    else $error("result index beyond the loaded burst");

  a_done_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == nfcs_pkg::KIND_DONE) |-> (last && phase == nfcs_pkg::PH_IDLE))
    else $error("done result not final or sequencer not idle");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !batch_free) |=> (s1_valid && $stable(s1_op) && $stable(s1_read_data)))
    else $error("stalled item in the input register was lost");

  a_phase_matches_request: assert property (@(posedge clk) disable iff (rst)
    (phase == nfcs_pkg::PH_PROG_POLL || phase == nfcs_pkg::PH_PROG_VERIFY)
      |-> (active_request == nfcs_pkg::OP_PROGRAM))
    else $error("program phase without a program request");

endmodule

@@ verif/nor_flash_command_sequencer_top_test.sv @@
// ----------------------------------------------------------------------------
// NOR flash command sequencer testbench
// Drives program, erase and read-ID requests and the flash read responses
// that follow them, predicts every bus cycle and completion the sequencer
// should produce, and compares each output transaction with the prediction.
// ----------------------------------------------------------------------------
module nor_flash_command_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_WIDTH     = 22;
  localparam int SECTOR_WORDS   = 2048;
  localparam int MAX_LENGTH     = 4194304;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    nfcs_pkg::op_t op;
    logic [21:0]   address;
    logic [15:0]   wdata;
    logic [22:0]   length;
    logic [15:0]   rdata;
  } flash_item_t;

  typedef struct packed {
    nfcs_pkg::kind_t   kind;
    logic [21:0]       addr;
    logic [15:0]       data;
    nfcs_pkg::status_t status;
    logic              last;
  } bus_cycle_t;

  class flash_cycle_scoreboard;
    logic [25:0]      poll_limit;
    logic [21:0]      bus_base;
    nfcs_pkg::phase_t phase;
    nfcs_pkg::op_t    active_op;
    logic [21:0]      target;
    logic [15:0]      expected_word;
    logic [22:0]      erase_left;
    logic             toggle_prev;
    logic [25:0]      mismatches;
    logic             first_read;
    bus_cycle_t       bus_cycles_due[$];
    int               checked;
    int               errors;
    int               completions;
    int               timeouts;
    int               verify_failures;

    function new();
      poll_limit    = nfcs_pkg::POLL_RESET;
      bus_base      = '0;
      phase         = nfcs_pkg::PH_IDLE;
      active_op     = nfcs_pkg::OP_PROGRAM;
      target        = '0;
      expected_word = '0;
      erase_left    = '0;
      toggle_prev   = 1'b0;
      mismatches    = '0;
      first_read    = 1'b0;
    endfunction

    function void write_register(nfcs_pkg::cfg_reg_t idx, logic [25:0] value);
      if (idx == nfcs_pkg::CFG_POLL_LIMIT) begin
        poll_limit = value;
      end else begin
        bus_base = value[21:0];
      end
    endfunction

    function int pending();
      return bus_cycles_due.size();
    endfunction

    function logic [21:0] rebase(logic [21:0] offset);
      return bus_base + offset;
    endfunction

    function void push_cycle(nfcs_pkg::kind_t k, logic [21:0] a, logic [15:0] d,
                             nfcs_pkg::status_t s);
      bus_cycle_t c;
      c.kind   = k;
      c.addr   = a;
      c.data   = d;
      c.status = s;
      c.last   = 1'b0;
      bus_cycles_due.push_back(c);
    endfunction

    function void finish_request(logic [15:0] d, nfcs_pkg::status_t s);
      push_cycle(nfcs_pkg::KIND_DONE, '0, d, s);
      phase = nfcs_pkg::PH_IDLE;
      completions++;
      if (s == nfcs_pkg::ST_TIMEOUT) timeouts++;
      if (s == nfcs_pkg::ST_MISMATCH) verify_failures++;
    endfunction

    function void start_poll();
      first_read = 1'b1;
      mismatches = '0;
      push_cycle(nfcs_pkg::KIND_READ, target, '0, nfcs_pkg::ST_OK);
    endfunction

    // Toggling has stopped once two consecutive reads show the same DQ6.
    function nfcs_pkg::poll_t poll_response(logic [15:0] rd);
      logic t;
      t = |(rd & nfcs_pkg::TOGGLE_BIT);
      if (first_read) begin
        first_read  = 1'b0;
        toggle_prev = t;
        push_cycle(nfcs_pkg::KIND_READ, target, '0, nfcs_pkg::ST_OK);
        return nfcs_pkg::POLL_AGAIN;
      end
      if (t == toggle_prev) return nfcs_pkg::POLL_SETTLED;
      toggle_prev = t;
      if (mismatches >= poll_limit) return nfcs_pkg::POLL_TIMEOUT;
      mismatches++;
      push_cycle(nfcs_pkg::KIND_READ, target, '0, nfcs_pkg::ST_OK);
      return nfcs_pkg::POLL_AGAIN;
    endfunction

    function void unlock_command(logic [15:0] cmd);
      push_cycle(nfcs_pkg::KIND_WRITE, rebase(22'(nfcs_pkg::UNLOCK_A1)),
                 nfcs_pkg::UNLOCK_D1, nfcs_pkg::ST_OK);
      push_cycle(nfcs_pkg::KIND_WRITE, rebase(22'(nfcs_pkg::UNLOCK_A2)),
                 nfcs_pkg::UNLOCK_D2, nfcs_pkg::ST_OK);
      push_cycle(nfcs_pkg::KIND_WRITE, rebase(22'(nfcs_pkg::UNLOCK_A1)), cmd,
                 nfcs_pkg::ST_OK);
    endfunction

    function void erase_sector();
      unlock_command(nfcs_pkg::CMD_ERASE_SETUP);
      push_cycle(nfcs_pkg::KIND_WRITE, rebase(22'(nfcs_pkg::UNLOCK_A1)),
                 nfcs_pkg::UNLOCK_D1, nfcs_pkg::ST_OK);
      push_cycle(nfcs_pkg::KIND_WRITE, rebase(22'(nfcs_pkg::UNLOCK_A2)),
                 nfcs_pkg::UNLOCK_D2, nfcs_pkg::ST_OK);
      push_cycle(nfcs_pkg::KIND_WRITE, target, nfcs_pkg::CMD_SECTOR, nfcs_pkg::ST_OK);
      phase = nfcs_pkg::PH_ERASE_POLL;
      start_poll();
    endfunction

    // Records an accepted input transaction and queues the bus cycles it causes.
    function int note_transaction(flash_item_t item);
      int               queued;
      nfcs_pkg::poll_t  verdict;
      queued = bus_cycles_due.size();
      if (item.op != nfcs_pkg::OP_RESPONSE) begin
        if (phase != nfcs_pkg::PH_IDLE) return 0;
        active_op = item.op;
        case (item.op)
          nfcs_pkg::OP_PROGRAM: begin
            target        = rebase(item.address);
            expected_word = item.wdata;
            unlock_command(nfcs_pkg::CMD_PROGRAM);
            push_cycle(nfcs_pkg::KIND_WRITE, target, item.wdata, nfcs_pkg::ST_OK);
            phase = nfcs_pkg::PH_PROG_POLL;
            start_poll();
          end
          nfcs_pkg::OP_ERASE: begin
            if (item.length == 0) begin
              finish_request('0, nfcs_pkg::ST_OK);
            end else begin
              target     = rebase(item.address);
              erase_left = item.length;
              phase      = nfcs_pkg::PH_ERASE_PRE;
              start_poll();
            end
          end
          default: begin
            unlock_command(nfcs_pkg::CMD_ID);
            push_cycle(nfcs_pkg::KIND_READ, rebase(22'd1), '0, nfcs_pkg::ST_OK);
            phase = nfcs_pkg::PH_ID_READ;
          end
        endcase
      end else begin
        case (phase)
          nfcs_pkg::PH_PROG_POLL: begin
            verdict = poll_response(item.rdata);
            if (verdict == nfcs_pkg::POLL_SETTLED) begin
              push_cycle(nfcs_pkg::KIND_READ, target, '0, nfcs_pkg::ST_OK);
              phase = nfcs_pkg::PH_PROG_VERIFY;
            end else if (verdict == nfcs_pkg::POLL_TIMEOUT) begin
              finish_request('0, nfcs_pkg::ST_TIMEOUT);
            end
          end
          nfcs_pkg::PH_PROG_VERIFY: begin
            if (item.rdata == expected_word) begin
              finish_request('0, nfcs_pkg::ST_OK);
            end else begin
              push_cycle(nfcs_pkg::KIND_WRITE, target, nfcs_pkg::CMD_RESET,
                         nfcs_pkg::ST_OK);
              finish_request('0, nfcs_pkg::ST_MISMATCH);
            end
          end
          nfcs_pkg::PH_ERASE_PRE: begin
            // The outcome of the pre-erase poll does not matter, a timeout included.
            verdict = poll_response(item.rdata);
            if (verdict != nfcs_pkg::POLL_AGAIN) erase_sector();
          end
          nfcs_pkg::PH_ERASE_POLL: begin
            verdict = poll_response(item.rdata);
            if (verdict == nfcs_pkg::POLL_SETTLED) begin
              if (erase_left <= SECTOR_WORDS) begin
                erase_left = '0;
                finish_request('0, nfcs_pkg::ST_OK);
              end else begin
                erase_left = erase_left - 23'(SECTOR_WORDS);
                target     = target + 22'(SECTOR_WORDS);
                phase      = nfcs_pkg::PH_ERASE_PRE;
                start_poll();
              end
            end else if (verdict == nfcs_pkg::POLL_TIMEOUT) begin
              finish_request('0, nfcs_pkg::ST_TIMEOUT);
            end
          end
          nfcs_pkg::PH_ID_READ: begin
            push_cycle(nfcs_pkg::KIND_WRITE, rebase(22'd0), nfcs_pkg::CMD_RESET,
                       nfcs_pkg::ST_OK);
            finish_request(item.rdata, nfcs_pkg::ST_OK);
          end
          default: ;
        endcase
      end
      if (bus_cycles_due.size() > queued) begin
        bus_cycles_due[bus_cycles_due.size() - 1].last = 1'b1;
      end
      return bus_cycles_due.size() - queued;
    endfunction

    function void check_cycle(nfcs_pkg::kind_t k, logic [21:0] a, logic [15:0] d,
                              nfcs_pkg::status_t s, logic l);
      bus_cycle_t want;
      checked++;
      if (bus_cycles_due.size() == 0) begin
        $error("unexpected output transaction: kind %0d address %h data %h", k, a, d);
        errors++;
        return;
      end
      want = bus_cycles_due.pop_front();
      if (want.kind !== k) begin
        $error("kind: expected %0d, got %0d", want.kind, k);
        errors++;
      end
      if (want.addr !== a) begin
        $error("bus_address: expected %h, got %h", want.addr, a);
        errors++;
      end
      if (want.data !== d) begin
        $error("bus_data: expected %h, got %h", want.data, d);
        errors++;
      end
      if (want.status !== s) begin
        $error("status: expected %0d, got %0d", want.status, s);
        errors++;
      end
      if (want.last !== l) begin
        $error("last: expected %0d, got %0d", want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic [21:0] address;
  logic [15:0] write_data;
  logic [22:0] length;
  logic [15:0] read_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [21:0] bus_address;
  logic [15:0] bus_data;
  logic [1:0]  status;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [25:0] cfg_data;

  flash_cycle_scoreboard sb;
  bit steady;
  int served;
  int settings;
  int idle_cycles;

  nor_flash_command_sequencer_top #(
    .ADDR_WIDTH  (ADDR_WIDTH),
    .SECTOR_WORDS(SECTOR_WORDS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .address    (address),
    .write_data (write_data),
    .length     (length),
    .read_data  (read_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .bus_address(bus_address),
    .bus_data   (bus_data),
    .status     (status),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_cycle(nfcs_pkg::kind_t'(kind), bus_address, bus_data,
                     nfcs_pkg::status_t'(status), last);
    end
  end

  // Counts cycles in which no transaction moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("nor_flash_command_sequencer_top_test failed");
        $finish;
      end
    end
  end

  function automatic flash_item_t make_item(nfcs_pkg::op_t op, logic [21:0] a,
                                            logic [15:0] w, logic [22:0] len,
                                            logic [15:0] rd);
    flash_item_t item;
    item.op      = op;
    item.address = a;
    item.wdata   = w;
    item.length  = len;
    item.rdata   = rd;
    return item;
  endfunction

  // Long erases are only asked for when a short poll limit lets them end early.
  function automatic logic [22:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 25 && sb.poll_limit <= 8) return 23'($urandom_range(MAX_LENGTH, 0));
    return 23'($urandom_range(3 * SECTOR_WORDS, 1));
  endfunction

  function automatic logic [15:0] pick_read_data();
    logic [15:0] word;
    logic        settle;
    logic        t;
    word = 16'($urandom());
    case (sb.phase) inside
      nfcs_pkg::PH_PROG_POLL, nfcs_pkg::PH_ERASE_PRE, nfcs_pkg::PH_ERASE_POLL: begin
        if (!sb.first_read) begin
          settle = ($urandom_range(99) < 35) &&
                   !(sb.phase == nfcs_pkg::PH_ERASE_POLL &&
                     sb.erase_left > 4 * SECTOR_WORDS);
          t    = settle ? sb.toggle_prev : ~sb.toggle_prev;
          word = (word & ~nfcs_pkg::TOGGLE_BIT) |
                 (t ? nfcs_pkg::TOGGLE_BIT : 16'h0000);
        end
      end
      nfcs_pkg::PH_PROG_VERIFY: begin
        if ($urandom_range(99) < 70) begin
          word = sb.expected_word;
        end else begin
          word = sb.expected_word ^ 16'($urandom_range(16'hffff, 1));
        end
      end
      default: ;
    endcase
    return word;
  endfunction

  function automatic flash_item_t next_item(bit finishing);
    flash_item_t item;
    int          r;
    item = make_item(nfcs_pkg::OP_RESPONSE, 22'($urandom()), 16'($urandom()),
                     23'($urandom_range(MAX_LENGTH, 0)), 16'($urandom()));
    if (!finishing && $urandom_range(99) < 10) begin
      // Noise: anything at all, often a request while busy or a stray response.
      item.op = nfcs_pkg::op_t'($urandom_range(3));
      if (item.op == nfcs_pkg::OP_ERASE) item.length = pick_length();
    end else if (sb.phase == nfcs_pkg::PH_IDLE) begin
      r = $urandom_range(99);
      item.op = (r < 40) ? nfcs_pkg::OP_PROGRAM :
                (r < 80) ? nfcs_pkg::OP_ERASE : nfcs_pkg::OP_READ_ID;
      if (item.op == nfcs_pkg::OP_ERASE) item.length = pick_length();
    end else begin
      item.rdata = pick_read_data();
    end
    return item;
  endfunction

  // Called at a rising edge; returns once the item is taken and any idle gap ends.
  task automatic send_item(flash_item_t item);
    in_valid   <= 1'b1;
    operation  <= item.op;
    address    <= item.address;
    write_data <= item.wdata;
    length     <= item.length;
    read_data  <= item.rdata;
    do @(posedge clk); while (!in_ready);
    if (sb.note_transaction(item) > 0) served++;
    if (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic write_register(nfcs_pkg::cfg_reg_t idx, logic [25:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [25:0] limit, logic [21:0] base);
    write_register(nfcs_pkg::CFG_POLL_LIMIT, limit);
    write_register(nfcs_pkg::CFG_BUS_BASE, base);
    settings++;
  endtask

  task automatic run_random(int count);
    int target_served;
    target_served = served + count;
    while (served < target_served || sb.phase != nfcs_pkg::PH_IDLE) begin
      send_item(next_item(served >= target_served));
    end
    drain();
  endtask

  task automatic run_directed();
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'h1234));
    // Program with a poll that times out on its second mismatch.
    send_item(make_item(nfcs_pkg::OP_PROGRAM, 22'h3fffff, 16'hffff, 23'h7fffff >> 1,
                        16'h0));
    send_item(make_item(nfcs_pkg::OP_PROGRAM, 22'h0, 16'h0, 23'h0, 16'h0));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'h0000));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'hffff));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'h0000));
    // Program that settles and then fails its verify read.
    send_item(make_item(nfcs_pkg::OP_PROGRAM, 22'h0, 16'h0000, 23'h0, 16'h0));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'h0040));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'h0040));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'h0001));
    // Program that succeeds.
    send_item(make_item(nfcs_pkg::OP_PROGRAM, 22'h001234, 16'ha5a5, 23'h0, 16'h0));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'h0000));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'h0000));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'ha5a5));
    send_item(make_item(nfcs_pkg::OP_ERASE, 22'h2aaaaa, 16'h0, 23'h0, 16'h0));
    // Whole-device erase: pre-erase poll times out, then the sector poll does.
    send_item(make_item(nfcs_pkg::OP_ERASE, 22'h3fffff, 16'h0, 23'(MAX_LENGTH), 16'h0));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'h0000));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'h0040));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'h0000));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'hffbf));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'hffff));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'hffbf));
    send_item(make_item(nfcs_pkg::OP_READ_ID, 22'h0, 16'h0, 23'h0, 16'h0));
    send_item(make_item(nfcs_pkg::OP_RESPONSE, 22'h0, 16'h0, 23'h0, 16'hbeef));
    drain();
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    operation   = '0;
    address     = '0;
    write_data  = '0;
    length      = '0;
    read_data   = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = 1'b0;
    cfg_data    = '0;
    steady      = 1'b0;
    served      = 0;
    settings    = 1;
    idle_cycles = 0;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_random(96);
    configure(26'd1, 22'h3ffff0);
    run_directed();
    configure(26'd0, 22'h3fffff);
    run_random(80);
    configure(26'd3, 22'($urandom()));
    steady = 1'b1;
    run_random(96);
    steady = 1'b0;
    configure(26'h3ffffff, 22'h0);
    run_random(96);
    configure(26'd2, 22'h3ff800);
    run_random(96);

    $display("Sent %0d live transactions under %0d register settings; %0d bus cycles checked.",
             served, settings, sb.checked);
    $display("Requests completed: %0d, poll timeouts: %0d, verify failures: %0d.",
             sb.completions, sb.timeouts, sb.verify_failures);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("nor_flash_command_sequencer_top_test passed");
    end else begin
      $display("nor_flash_command_sequencer_top_test failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/nfcs_pkg.sv
hw/rtl/nor_flash_command_sequencer_top.sv
verif/nor_flash_command_sequencer_top_test.sv
